// ===== hw/rtl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants for the humidity/temperature poller
// Poll stage codes, bus command codes, register indexes, and the structs
// passed between the poller's modules.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int TEMP_W     = 14;
    localparam int HUM_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int STAGE_W    = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 14;

    localparam logic [TEMP_W-1:0] TEMP_MIN_CHANGE_RST = TEMP_W'(6);
    localparam logic [HUM_W-1:0]  HUM_MIN_CHANGE_RST  = HUM_W'(1);

    // Status bits 7:6 of the first received byte
    localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hC0;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN_CHANGE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_MIN_CHANGE  = 8'd1;

    // Poll sequence stages; all others just count
    localparam logic [STAGE_W-1:0] STAGE_START     = 8'd0;
    localparam logic [STAGE_W-1:0] STAGE_RESTART   = 8'd1;
    localparam logic [STAGE_W-1:0] STAGE_MEAS_WAIT = 8'd2;
    localparam logic [STAGE_W-1:0] STAGE_READ      = 8'd4;
    localparam logic [STAGE_W-1:0] STAGE_CHECK     = 8'd5;
    localparam logic [STAGE_W-1:0] STAGE_TEMP_DONE = 8'd6;
    localparam logic [STAGE_W-1:0] STAGE_HUM       = 8'd7;
    localparam logic [STAGE_W-1:0] STAGE_HUM_DONE  = 8'd8;
    localparam logic [STAGE_W-1:0] STAGE_HOLD      = 8'd64;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_bus_cmd;

    typedef struct packed {
        logic [TEMP_W-1:0] temp_min_change;
        logic [HUM_W-1:0]  hum_min_change;
    } t_cfg;

    typedef struct packed {
        logic              bus_error;
        logic              release_request;
        logic              transfer_active;
        logic              bus_claimed;
        logic [BYTE_W-1:0] rx_byte0;
        logic [BYTE_W-1:0] rx_byte1;
        logic [BYTE_W-1:0] rx_byte2;
        logic [BYTE_W-1:0] rx_byte3;
    } t_item;

    typedef struct packed {
        t_bus_cmd          bus_command;
        logic              ack_release;
        logic              free_bus;
        logic              temp_updated;
        logic              humidity_updated;
        logic [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]  humidity;
    } t_result;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic [TEMP_W-1:0]  last_temperature;
        logic [HUM_W-1:0]   last_humidity;
    } t_state;

endpackage

// ===== hw/rtl/hts_ifs.sv =====
// ----------------------------------------------------------------------------
// hts_ifs: valid/ready channels of the humidity/temperature poller
// Poll tick channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface hts_item_if;
    logic                                valid;
    logic                                ready;
    logic                                bus_error;
    logic                                release_request;
    logic                                transfer_active;
    logic                                bus_claimed;
    logic [hts_pkg::BYTE_W-1:0]          rx_byte0;
    logic [hts_pkg::BYTE_W-1:0]          rx_byte1;
    logic [hts_pkg::BYTE_W-1:0]          rx_byte2;
    logic [hts_pkg::BYTE_W-1:0]          rx_byte3;

    modport source (
        output valid, bus_error, release_request, transfer_active, bus_claimed,
               rx_byte0, rx_byte1, rx_byte2, rx_byte3,
        input  ready
    );
    modport sink (
        input  valid, bus_error, release_request, transfer_active, bus_claimed,
               rx_byte0, rx_byte1, rx_byte2, rx_byte3,
        output ready
    );
endinterface

interface hts_res_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          bus_command;
    logic                                ack_release;
    logic                                free_bus;
    logic                                temp_updated;
    logic                                humidity_updated;
    logic [hts_pkg::TEMP_W-1:0]          temperature;
    logic [hts_pkg::HUM_W-1:0]           humidity;

    modport source (
        output valid, bus_command, ack_release, free_bus, temp_updated,
               humidity_updated, temperature, humidity,
        input  ready
    );
    modport sink (
        input  valid, bus_command, ack_release, free_bus, temp_updated,
               humidity_updated, temperature, humidity,
        output ready
    );
endinterface

interface hts_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hts_pkg::CFG_IDX_W-1:0]       index;
    logic [hts_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hts_cfg_regs: change-threshold registers
// Decodes register writes and holds the temperature and humidity thresholds.
// ----------------------------------------------------------------------------
module hts_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [hts_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output hts_pkg::t_cfg                   o_cfg
);

    hts_pkg::t_cfg r_cfg;
    hts_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                hts_pkg::CFG_TEMP_MIN_CHANGE: begin
                    n_cfg.temp_min_change = i_wr_data[hts_pkg::TEMP_W-1:0];
                end
                hts_pkg::CFG_HUM_MIN_CHANGE: begin
                    n_cfg.hum_min_change = i_wr_data[hts_pkg::HUM_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_min_change <= hts_pkg::TEMP_MIN_CHANGE_RST;
            r_cfg.hum_min_change  <= hts_pkg::HUM_MIN_CHANGE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/hts_step.sv =====
// ----------------------------------------------------------------------------
// hts_step: one poll tick of the sequencer and change filters
// Given the registered tick and the current state, forms the next state
// and the result item.
// ----------------------------------------------------------------------------
module hts_step (
    input  hts_pkg::t_item   i_item,
    input  hts_pkg::t_state  i_state,
    input  hts_pkg::t_cfg    i_cfg,
    output hts_pkg::t_state  o_state,
    output hts_pkg::t_result o_result
);

    logic [hts_pkg::TEMP_W-1:0]  w_temp;
    logic [hts_pkg::HUM_W-1:0]   w_hum;
    logic [hts_pkg::TEMP_W-1:0]  w_temp_diff;
    logic [hts_pkg::HUM_W-1:0]   w_hum_diff;
    logic                        w_temp_chg;
    logic                        w_hum_chg;
    logic                        w_status_bad;
    logic [hts_pkg::STAGE_W-1:0] w_stage1;

    assign w_temp = {i_item.rx_byte2, i_item.rx_byte3[7:2]};
    assign w_hum  = {i_item.rx_byte0[5:0], i_item.rx_byte1[7:6]};

    assign w_temp_diff = (w_temp > i_state.last_temperature)
                       ? w_temp - i_state.last_temperature
                       : i_state.last_temperature - w_temp;
    assign w_hum_diff  = (w_hum > i_state.last_humidity)
                       ? w_hum - i_state.last_humidity
                       : i_state.last_humidity - w_hum;

    assign w_temp_chg   = w_temp_diff > i_cfg.temp_min_change;
    assign w_hum_chg    = w_hum_diff > i_cfg.hum_min_change;
    assign w_status_bad = (i_item.rx_byte0 & hts_pkg::STATUS_MASK) != '0;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.bus_command = hts_pkg::CMD_NONE;

        // sequence and temperature
        if (i_item.bus_error || i_item.release_request) begin
            if (i_state.stage != hts_pkg::STAGE_START) begin
                o_state.stage        = hts_pkg::STAGE_HOLD;
                o_result.ack_release = i_item.release_request;
            end
        end else if (!i_item.transfer_active) begin
            unique case (i_state.stage)
                hts_pkg::STAGE_START: begin
                    if (!i_item.bus_claimed) begin
                        o_result.bus_command = hts_pkg::CMD_WRITE;
                        o_state.stage        = hts_pkg::STAGE_MEAS_WAIT;
                    end
                end
                hts_pkg::STAGE_RESTART: begin
                    o_result.bus_command = hts_pkg::CMD_WRITE;
                    o_state.stage        = hts_pkg::STAGE_MEAS_WAIT;
                end
                hts_pkg::STAGE_READ: begin
                    o_result.bus_command = hts_pkg::CMD_READ;
                    o_state.stage        = hts_pkg::STAGE_CHECK;
                end
                hts_pkg::STAGE_CHECK: begin
                    if (w_status_bad) begin
                        o_state.stage = hts_pkg::STAGE_READ;
                    end else begin
                        if (w_temp_chg) begin
                            o_state.last_temperature = w_temp;
                            o_result.temp_updated    = 1'b1;
                        end
                        o_state.stage = hts_pkg::STAGE_TEMP_DONE;
                    end
                end
                default: begin
                    o_state.stage = i_state.stage + 1'b1;
                end
            endcase
        end

        // humidity, on the stage the first step left
        w_stage1 = o_state.stage;
        if (w_stage1 == hts_pkg::STAGE_HUM) begin
            o_state.stage     = hts_pkg::STAGE_HUM_DONE;
            o_result.free_bus = 1'b1;
            if (w_hum_chg) begin
                o_state.last_humidity     = w_hum;
                o_result.humidity_updated = 1'b1;
            end
        end

        o_result.temperature = o_state.last_temperature;
        o_result.humidity    = o_state.last_humidity;
    end

endmodule

// ===== hw/rtl/humidity_temp_sensor_poller.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_sensor_poller: poll sequencer for a humidity/temperature sensor
// Order: a tick transfer loads the input register, and the result register
//   loads from it when it advances, which a waiting result can hold off.
// Throughput: one tick per cycle; the input and result registers form a
//   two-entry pipeline, so a waiting result stops new ticks only when both fill.
// Reset (synchronous, active low): empties both registers, sets stage and the
//   stored values to 0 and the thresholds to 6 and 1.
// ----------------------------------------------------------------------------
module humidity_temp_sensor_poller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hts_item_if.sink       i_item,
    hts_res_if.source      o_result,
    hts_cfg_if.sink        i_cfg
);

    // Pipeline control: the result register advances when empty or taken,
    // and the input register refills when it is empty or advancing.
    logic w_res_adv;
    logic w_in_ready;
    logic w_in_xfer;
    logic w_step_en;

    // Input register holds one poll tick
    logic             r_item_vld;
    hts_pkg::t_item   r_item;

    // Result register
    logic             r_res_vld;
    hts_pkg::t_result r_res;

    // Sequencer state: stage counter and stored values
    hts_pkg::t_state  r_state;
    hts_pkg::t_state  n_state;
    hts_pkg::t_result n_res;

    hts_pkg::t_cfg    w_cfg;

    assign w_res_adv  = !r_res_vld || o_result.ready;
    assign w_in_ready = !r_item_vld || w_res_adv;
    assign w_in_xfer  = i_item.valid && w_in_ready;
    assign w_step_en  = r_item_vld && w_res_adv;

    assign i_item.ready = w_in_ready;
    assign i_cfg.ready  = 1'b1;

    // Threshold registers; the user must write them only while idle (not enforced here)
    hts_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    // One tick of sequencing and filtering between the two registers
    hts_step u_step (
        .i_item   (r_item),
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Capture the tick payload on every transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item.bus_error       <= i_item.bus_error;
            r_item.release_request <= i_item.release_request;
            r_item.transfer_active <= i_item.transfer_active;
            r_item.bus_claimed     <= i_item.bus_claimed;
            r_item.rx_byte0        <= i_item.rx_byte0;
            r_item.rx_byte1        <= i_item.rx_byte1;
            r_item.rx_byte2        <= i_item.rx_byte2;
            r_item.rx_byte3        <= i_item.rx_byte3;
        end
    end

    // Load the result only when a tick actually advances
    always_ff @(posedge i_clk) begin
        if (w_step_en) begin
            r_res <= n_res;
        end
    end

    // Control state; the sequencer state moves once per processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_res_vld  <= 1'b0;
            r_state    <= '0;
        end else begin
            if (w_in_ready) begin
                r_item_vld <= i_item.valid;
            end
            if (w_res_adv) begin
                r_res_vld <= r_item_vld;
            end
            if (w_step_en) begin
                r_state <= n_state;
            end
        end
    end

    assign o_result.valid            = r_res_vld;
    assign o_result.bus_command      = r_res.bus_command;
    assign o_result.ack_release      = r_res.ack_release;
    assign o_result.free_bus         = r_res.free_bus;
    assign o_result.temp_updated     = r_res.temp_updated;
    assign o_result.humidity_updated = r_res.humidity_updated;
    assign o_result.temperature      = r_res.temperature;
    assign o_result.humidity         = r_res.humidity;

endmodule

// ===== hw/rtl/hts_checker.sv =====
// ----------------------------------------------------------------------------
// hts_checker: port-level checks for the humidity/temperature poller
// Watches the result channel and checks the stored values and bus events.
// ----------------------------------------------------------------------------
module hts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [1:0]                 i_bus_command,
    input logic                       i_ack_release,
    input logic                       i_free_bus,
    input logic                       i_temp_updated,
    input logic                       i_humidity_updated,
    input logic [hts_pkg::TEMP_W-1:0] i_temperature,
    input logic [hts_pkg::HUM_W-1:0]  i_humidity
);

    logic                       w_xfer;
    logic [hts_pkg::TEMP_W-1:0] r_last_temp;
    logic [hts_pkg::HUM_W-1:0]  r_last_hum;

    assign w_xfer = i_res_valid && i_res_ready;

    // Track values of the last transferred result; reset values are 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_temp <= '0;
            r_last_hum  <= '0;
        end else if (w_xfer) begin
            r_last_temp <= i_temperature;
            r_last_hum  <= i_humidity;
        end
    end

    a_temp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !i_temp_updated |-> i_temperature == r_last_temp)
        else $error("temperature changed without update flag");

    a_hum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !i_humidity_updated |-> i_humidity == r_last_hum)
        else $error("humidity changed without update flag");

    a_no_cmd_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_free_bus || i_ack_release)
            |-> i_bus_command == hts_pkg::CMD_NONE && !(i_free_bus && i_ack_release))
        else $error("bus command issued with release or free");

    a_cmd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_bus_command != 2'd3)
        else $error("illegal bus command");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind humidity_temp_sensor_poller hts_checker u_hts_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_res_valid        (o_result.valid),
    .i_res_ready        (o_result.ready),
    .i_bus_command      (o_result.bus_command),
    .i_ack_release      (o_result.ack_release),
    .i_free_bus         (o_result.free_bus),
    .i_temp_updated     (o_result.temp_updated),
    .i_humidity_updated (o_result.humidity_updated),
    .i_temperature      (o_result.temperature),
    .i_humidity         (o_result.humidity)
);
